// File: rtl/core/isq_pkg.sv
`timescale 1ns / 1ps

package isq_pkg;

	// Widths of the stream fields.
	localparam int OP_W    = 3;
	localparam int POS_W   = 7;
	localparam int ITEM_W  = 32;
	localparam int VALUE_W = 32;
	localparam int TOTAL_W = 7;
	localparam int STAT_W  = 2;

	// Packed word widths, padded to whole bytes.
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 112;

	// Index and count fields of the cell control word cover the largest store.
	localparam int CNT_MAX_W = 13;

	typedef enum logic [OP_W-1:0] {
		OP_ADD_FIRST  = 3'd0,
		OP_ADD_LAST   = 3'd1,
		OP_DROP_FIRST = 3'd2,
		OP_DROP_LAST  = 3'd3,
		OP_INSERT     = 3'd4,
		OP_ERASE      = 3'd5,
		OP_READ       = 3'd6,
		OP_CLEAR      = 3'd7
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Broadcast to every slot cell for one operation.
	typedef struct packed {
		logic                 ins;
		logic                 del;
		logic [CNT_MAX_W-1:0] idx;
		logic [CNT_MAX_W-1:0] cnt;
	} cell_ctrl_t;

endpackage

// File: rtl/core/isq_cell.sv
`timescale 1ns / 1ps

module isq_cell #(
	parameter int IDX        = 0,
	parameter int DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  isq_pkg::cell_ctrl_t    ctrl,
	input  logic [DATA_WIDTH-1:0]  val,
	input  logic [DATA_WIDTH-1:0]  left,
	input  logic [DATA_WIDTH-1:0]  right,
	output logic [DATA_WIDTH-1:0]  data
);
	import isq_pkg::*;

	localparam logic [CNT_MAX_W-1:0] K  = CNT_MAX_W'(IDX);
	localparam logic [CNT_MAX_W-1:0] K1 = CNT_MAX_W'(IDX + 1);

	logic [DATA_WIDTH-1:0] data_q;

	// Insert opens a gap at idx by moving everything from idx up one slot;
	// erase closes it by pulling the upper neighbors down.
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (K == ctrl.idx) begin
				data_q <= val;
			end else if (K > ctrl.idx && K <= ctrl.cnt) begin
				data_q <= left;
			end
		end else if (ctrl.del) begin
			if (K >= ctrl.idx && K1 < ctrl.cnt) begin
				data_q <= right;
			end
		end
	end

	assign data = data_q;

endmodule

// File: rtl/core/isq_sel_tree.sv
`timescale 1ns / 1ps

module isq_sel_tree #(
	parameter int N = 64,
	parameter int W = 64
) (
	input  logic         clk,
	input  logic [W-1:0] leaf [N],
	output logic [W-1:0] root
);
	localparam int LEVELS = $clog2(N);

	logic [W-1:0] node_q [0:LEVELS][0:N-1];

	// Every leaf but the selected one is zero, so an OR tree selects.
	for (genvar j = 0; j < N; j++) begin : g_leaf
		always_ff @(posedge clk) begin
			node_q[0][j] <= leaf[j];
		end
	end

	for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
		localparam int PC = (N + (1 << (l - 1)) - 1) >> (l - 1);
		for (genvar j = 0; j < N; j++) begin : g_node
			if (2 * j + 1 < PC) begin : g_pair
				always_ff @(posedge clk) begin
					node_q[l][j] <= node_q[l-1][2*j] | node_q[l-1][2*j+1];
				end
			end else if (2 * j < PC) begin : g_single
				always_ff @(posedge clk) begin
					node_q[l][j] <= node_q[l-1][2*j];
				end
			end else begin : g_none
				always_ff @(posedge clk) begin
					node_q[l][j] <= '0;
				end
			end
		end
	end

	assign root = node_q[LEVELS][0];

endmodule

// File: rtl/core/indexed_sequence_store.sv
`timescale 1ns / 1ps

// Ordered sequence store: each input word carries an operation (push or pop at
// either end, insert, erase or read at an index, clear) and returns one result
// word with the value read, the front and back values, the count, an empty flag
// and a status. The elements live in a row of slot cells; insert and erase move
// every element past the index by one cell in the same clock. The read and back
// values are picked out of the cells by a registered OR tree; the next word is
// accepted once the result is in the output register. Reset clears the count
// and the control state but not the slots; slot contents are never read
// before they are written.
module indexed_sequence_store #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// op[2:0], position[9:3], item_value[41:10], zero pad
	input  logic [isq_pkg::S_DATA_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// read_value[31:0], front_value[63:32], back_value[95:64],
	// element_total[102:96], is_empty[103], status[105:104], zero pad
	output logic [isq_pkg::M_DATA_W-1:0]  m_tdata
);
	import isq_pkg::*;

	localparam int IW     = $clog2(CAPACITY);
	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int PW     = (CW > POS_W) ? CW : POS_W;
	localparam int LEVELS = $clog2(CAPACITY);
	localparam int LAT    = LEVELS + 1;
	localparam int WW     = $clog2(LAT + 1);

	// Input fields.
	op_t                   op;
	logic [POS_W-1:0]      position;
	logic [ITEM_W-1:0]     item_value;
	logic [DATA_WIDTH-1:0] val;
	logic [PW-1:0]         pos_x;
	logic [PW-1:0]         cnt_x;

	assign op         = op_t'(s_tdata[OP_W-1:0]);
	assign position   = s_tdata[OP_W +: POS_W];
	assign item_value = s_tdata[OP_W+POS_W +: ITEM_W];
	assign val        = DATA_WIDTH'(item_value);

	// Control state.
	logic          busy_q;
	logic [WW-1:0] wait_q;
	logic [CW-1:0] count_q;
	logic          rd_en_q;
	logic [IW-1:0] rd_idx_q;
	logic [IW-1:0] back_idx_q;
	status_t       status_q;
	logic          m_tvalid_q;

	// Result register.
	logic [VALUE_W-1:0] read_value_q;
	logic [VALUE_W-1:0] front_value_q;
	logic [VALUE_W-1:0] back_value_q;
	logic [TOTAL_W-1:0] element_total_q;
	logic               is_empty_q;
	status_t            status_out_q;

	logic accept;
	logic load;
	logic full;
	logic nonempty;

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign load     = busy_q && (wait_q == '0) && (!m_tvalid_q || m_tready);
	assign full     = (count_q == CW'(CAPACITY));
	assign nonempty = (count_q != '0);
	assign pos_x    = PW'(position);
	assign cnt_x    = PW'(count_q);

	// Decode of one operation against the current count.
	status_t       st;
	logic          ins;
	logic          del;
	logic          rd_en;
	logic [CW-1:0] idx;
	logic [CW-1:0] cnt_nx;

	always_comb begin
		st     = ST_OK;
		ins    = 1'b0;
		del    = 1'b0;
		rd_en  = 1'b0;
		idx    = '0;
		cnt_nx = count_q;
		case (op)
			OP_ADD_FIRST: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					ins    = 1'b1;
					cnt_nx = CW'(count_q + 1'b1);
				end
			end
			OP_ADD_LAST: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					ins    = 1'b1;
					idx    = count_q;
					cnt_nx = CW'(count_q + 1'b1);
				end
			end
			OP_DROP_FIRST: begin
				if (nonempty) begin
					del    = 1'b1;
					cnt_nx = CW'(count_q - 1'b1);
				end
			end
			OP_DROP_LAST: begin
				if (nonempty) begin
					cnt_nx = CW'(count_q - 1'b1);
				end
			end
			OP_INSERT: begin
				if (pos_x > cnt_x) begin
					st = ST_RANGE;
				end else if (full) begin
					st = ST_FULL;
				end else begin
					ins    = 1'b1;
					idx    = CW'(pos_x);
					cnt_nx = CW'(count_q + 1'b1);
				end
			end
			OP_ERASE: begin
				if (pos_x >= cnt_x) begin
					st = ST_RANGE;
				end else begin
					del    = 1'b1;
					idx    = CW'(pos_x);
					cnt_nx = CW'(count_q - 1'b1);
				end
			end
			OP_READ: begin
				if (pos_x >= cnt_x) begin
					st = ST_RANGE;
				end else begin
					rd_en = 1'b1;
				end
			end
			OP_CLEAR: begin
				cnt_nx = '0;
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	cell_ctrl_t ctrl;

	assign ctrl.ins = accept && ins;
	assign ctrl.del = accept && del;
	assign ctrl.idx = CNT_MAX_W'(idx);
	assign ctrl.cnt = CNT_MAX_W'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			wait_q     <= '0;
			count_q    <= '0;
			rd_en_q    <= 1'b0;
			status_q   <= ST_OK;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q   <= 1'b1;
				wait_q   <= WW'(LAT);
				count_q  <= cnt_nx;
				rd_en_q  <= rd_en;
				status_q <= st;
			end else if (load) begin
				busy_q <= 1'b0;
			end else if (busy_q && wait_q != '0) begin
				wait_q <= WW'(wait_q - 1'b1);
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_idx_q   <= IW'(pos_x);
			back_idx_q <= IW'(cnt_nx - 1'b1);
		end
	end

	// Row of slot cells; slot 0 is the front.
	logic [DATA_WIDTH-1:0]   slot [CAPACITY];
	logic [2*DATA_WIDTH-1:0] leaf [CAPACITY];
	logic [2*DATA_WIDTH-1:0] root;

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [DATA_WIDTH-1:0] left;
		logic [DATA_WIDTH-1:0] right;

		if (k == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = slot[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = slot[k+1];
		end

		isq_cell #(
			.IDX        (k),
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.val   (val),
			.left  (left),
			.right (right),
			.data  (slot[k])
		);

		// Upper half carries the read value, lower half the back value.
		assign leaf[k] = {
			(rd_en_q && rd_idx_q == IW'(k)) ? slot[k] : DATA_WIDTH'(0),
			(nonempty && back_idx_q == IW'(k)) ? slot[k] : DATA_WIDTH'(0)
		};
	end

	isq_sel_tree #(
		.N (CAPACITY),
		.W (2 * DATA_WIDTH)
	) u_tree (
		.clk  (clk),
		.leaf (leaf),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (load) begin
			read_value_q    <= VALUE_W'(root[2*DATA_WIDTH-1:DATA_WIDTH]);
			back_value_q    <= VALUE_W'(root[DATA_WIDTH-1:0]);
			front_value_q   <= nonempty ? VALUE_W'(slot[0]) : '0;
			element_total_q <= TOTAL_W'(count_q);
			is_empty_q      <= !nonempty;
			status_out_q    <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DATA_W'({status_out_q, is_empty_q, element_total_q,
		back_value_q, front_value_q, read_value_q});

endmodule

// File: rtl/core/isq_checker.sv
`timescale 1ns / 1ps

module isq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [isq_pkg::M_DATA_W-1:0] m_tdata
);
	import isq_pkg::*;

	// A result word that is not taken stays unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// One operation at a time: no word is taken right after another.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an operation is in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[105:104] != 2'd3)
		else $error("undefined status code");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[103] == (m_tdata[102:96] == 7'd0))
		else $error("empty flag disagrees with count");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[103] |-> m_tdata[63:32] == 32'd0 && m_tdata[95:64] == 32'd0)
		else $error("empty sequence reports nonzero front or back");

endmodule

bind indexed_sequence_store isq_checker u_isq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: tb/tb_indexed_sequence_store.sv
`timescale 1ns / 1ps

module tb_indexed_sequence_store;
	import isq_pkg::*;

	localparam int DEPTH       = 64;
	localparam int IDLE_PCT    = 11;
	localparam int HOLD_AT     = 400;
	localparam int HOLD_LEN    = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int CALM_FROM   = 2000;
	localparam int CALM_TO     = 3500;
	localparam int ITEM_TARGET = 800;

	typedef struct {
		op_t              op;
		logic [POS_W-1:0] pos;
		logic [ITEM_W-1:0] val;
		bit               wait_drain;
	} seq_cmd_t;

	typedef struct packed {
		logic [VALUE_W-1:0] read_value;
		logic [VALUE_W-1:0] front_value;
		logic [VALUE_W-1:0] back_value;
		logic [TOTAL_W-1:0] element_total;
		logic               is_empty;
		status_t            status;
	} seq_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	seq_cmd_t    pend_q[$];
	seq_result_t expected_q[$];

	// Shadow of the sequence as the block should hold it.
	logic [VALUE_W-1:0] seq_slots [0:DEPTH-1];
	int                 seq_count = 0;

	// Count model used only while building stimulus, to aim positions.
	int gen_count = 0;

	int n_sent = 0;
	int n_recv = 0;
	int cyc = 0;
	int quiet = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit failed = 1'b0;
	logic calm;

	assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

	indexed_sequence_store u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	function automatic seq_result_t apply_seq_op(op_t op, logic [POS_W-1:0] pos,
			logic [ITEM_W-1:0] val);
		seq_result_t r;
		int p;
		int k;
		r = '0;
		r.status = ST_OK;
		p = pos;
		case (op)
			OP_ADD_FIRST: begin
				if (seq_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (k = seq_count; k > 0; k--)
						seq_slots[k] = seq_slots[k-1];
					seq_slots[0] = val;
					seq_count++;
				end
			end
			OP_ADD_LAST: begin
				if (seq_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					seq_slots[seq_count] = val;
					seq_count++;
				end
			end
			OP_DROP_FIRST: begin
				if (seq_count > 0) begin
					for (k = 0; k + 1 < seq_count; k++)
						seq_slots[k] = seq_slots[k+1];
					seq_count--;
				end
			end
			OP_DROP_LAST: begin
				if (seq_count > 0)
					seq_count--;
			end
			OP_INSERT: begin
				// The range check wins over the full check.
				if (p > seq_count) begin
					r.status = ST_RANGE;
				end else if (seq_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (k = seq_count; k > p; k--)
						seq_slots[k] = seq_slots[k-1];
					seq_slots[p] = val;
					seq_count++;
				end
			end
			OP_ERASE: begin
				if (p >= seq_count) begin
					r.status = ST_RANGE;
				end else begin
					for (k = p; k + 1 < seq_count; k++)
						seq_slots[k] = seq_slots[k+1];
					seq_count--;
				end
			end
			OP_READ: begin
				if (p >= seq_count)
					r.status = ST_RANGE;
				else
					r.read_value = seq_slots[p];
			end
			default: begin
				seq_count = 0;
			end
		endcase
		if (seq_count != 0) begin
			r.front_value = seq_slots[0];
			r.back_value  = seq_slots[seq_count-1];
		end
		r.element_total = seq_count[TOTAL_W-1:0];
		r.is_empty      = (seq_count == 0);
		return r;
	endfunction

	task automatic add_item(op_t op, int pos, logic [ITEM_W-1:0] val, bit wait_drain);
		seq_cmd_t c;
		c.op         = op;
		c.pos        = pos[POS_W-1:0];
		c.val        = val;
		c.wait_drain = wait_drain;
		pend_q.insert(pend_q.size(), c);
		case (op)
			OP_ADD_FIRST, OP_ADD_LAST:   if (gen_count < DEPTH) gen_count++;
			OP_DROP_FIRST, OP_DROP_LAST: if (gen_count > 0) gen_count--;
			OP_INSERT:                   if (pos <= gen_count && gen_count < DEPTH) gen_count++;
			OP_ERASE:                    if (pos < gen_count) gen_count--;
			OP_CLEAR:                    gen_count = 0;
			default:                     ;
		endcase
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			failed = 1'b1;
		end
	endtask

	// Driver: offers the next pending word and predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin : p_driver
		bit accepted;
		bit drained;
		seq_cmd_t c;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			accepted = s_tvalid && s_tready;
			if (accepted) begin
				expected_q.insert(expected_q.size(), apply_seq_op(op_t'(s_tdata[2:0]),
					s_tdata[9:3], s_tdata[41:10]));
				n_sent <= n_sent + 1;
			end
			drained = !accepted && !s_tvalid && (n_sent == n_recv);
			if (!s_tvalid || s_tready) begin
				if (pend_q.size() != 0 && (calm || $urandom_range(99, 0) >= IDLE_PCT) &&
						(!pend_q[0].wait_drain || drained)) begin
					c = pend_q[0];
					pend_q.delete(0);
					s_tvalid <= 1'b1;
					s_tdata  <= {6'b0, c.val, c.pos, c.op};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result word and drives the ready side.
	always @(posedge clk or negedge arst_n) begin : p_monitor
		seq_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_recv <= n_recv + 1;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, m_tdata);
					failed = 1'b1;
				end else begin
					want = expected_q[0];
					expected_q.delete(0);
					compare_field("read_value", want.read_value, m_tdata[31:0]);
					compare_field("front_value", want.front_value, m_tdata[63:32]);
					compare_field("back_value", want.back_value, m_tdata[95:64]);
					compare_field("element_total", 32'(want.element_total),
						32'(m_tdata[102:96]));
					compare_field("is_empty", 32'(want.is_empty), 32'(m_tdata[103]));
					compare_field("status", 32'(want.status), 32'(m_tdata[105:104]));
				end
			end
			// One long hold-off lets the block back up and stall its input.
			if (!hold_done && n_recv == HOLD_AT) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_LEN;
				m_tready  <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("tb_indexed_sequence_store NOT OK");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin : p_stimulus
		int blk;
		int mode;
		int len;
		int i;
		int r;
		int pos;
		op_t op;
		logic [ITEM_W-1:0] val;
		logic [ITEM_W-1:0] corner [4];

		corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};

		// Empty-sequence cases first, then small edits and reads at the edges.
		add_item(OP_DROP_FIRST, 0, 32'hFFFF_FFFF, 1'b0);
		add_item(OP_DROP_LAST, 0, 32'h0, 1'b0);
		add_item(OP_READ, 0, 32'h0, 1'b0);
		add_item(OP_ERASE, 0, 32'h0, 1'b0);
		add_item(OP_INSERT, 1, 32'h1111_1111, 1'b0);
		add_item(OP_INSERT, 0, 32'h0000_0000, 1'b0);
		add_item(OP_ADD_LAST, 0, 32'hFFFF_FFFF, 1'b0);
		add_item(OP_ADD_FIRST, 127, 32'h1234_5678, 1'b0);
		add_item(OP_INSERT, 1, 32'hA5A5_A5A5, 1'b0);
		add_item(OP_INSERT, 4, 32'h5A5A_5A5A, 1'b0);
		add_item(OP_READ, 0, 32'h0, 1'b0);
		add_item(OP_READ, 4, 32'h0, 1'b0);
		add_item(OP_READ, 5, 32'h0, 1'b0);
		add_item(OP_READ, 64, 32'h0, 1'b0);
		add_item(OP_ERASE, 2, 32'h0, 1'b0);
		add_item(OP_ERASE, 64, 32'h0, 1'b0);
		add_item(OP_INSERT, 64, 32'hDEAD_BEEF, 1'b0);
		add_item(OP_DROP_FIRST, 0, 32'h0, 1'b0);
		add_item(OP_DROP_LAST, 0, 32'h0, 1'b0);
		add_item(OP_CLEAR, 0, 32'h0, 1'b0);
		add_item(OP_DROP_LAST, 0, 32'h0, 1'b0);
		add_item(OP_ADD_LAST, 0, 32'h0000_0001, 1'b0);
		add_item(OP_READ, 0, 32'h0, 1'b0);

		// Random part in phases that grow the sequence to full, churn it, and
		// shrink it again, so that full and empty both come up repeatedly.
		blk = 0;
		while (pend_q.size() < ITEM_TARGET) begin
			mode = blk % 3;
			len = $urandom_range(120, 80);
			for (i = 0; i < len; i++) begin
				r = $urandom_range(99, 0);
				if (mode == 0) begin
					if (r < 30)      op = OP_ADD_LAST;
					else if (r < 55) op = OP_ADD_FIRST;
					else if (r < 85) op = OP_INSERT;
					else if (r < 91) op = OP_READ;
					else if (r < 95) op = OP_ERASE;
					else if (r < 98) op = OP_DROP_FIRST;
					else             op = OP_DROP_LAST;
				end else if (mode == 1) begin
					op = op_t'($urandom_range(6, 0));
					if (r < 2)
						op = OP_CLEAR;
				end else begin
					if (r < 25)      op = OP_DROP_FIRST;
					else if (r < 50) op = OP_DROP_LAST;
					else if (r < 75) op = OP_ERASE;
					else if (r < 85) op = OP_READ;
					else if (r < 95) op = OP_ADD_LAST;
					else if (r < 97) op = OP_INSERT;
					else             op = OP_CLEAR;
				end
				if ($urandom_range(99, 0) < 12)
					pos = $urandom_range(64, 0);
				else if (op == OP_INSERT)
					pos = $urandom_range(gen_count, 0);
				else if (gen_count > 0)
					pos = $urandom_range(gen_count - 1, 0);
				else
					pos = 0;
				if ($urandom_range(99, 0) < 20)
					val = corner[$urandom_range(3, 0)];
				else
					val = $urandom;
				add_item(op, pos, val, (i == 0) && (blk % 3 == 2));
			end
			blk++;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (pend_q.size() != 0 || s_tvalid || n_recv != n_sent)
			@(negedge clk);
		repeat (30) @(negedge clk);
		if (expected_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_q.size());
			failed = 1'b1;
		end
		if (!failed) begin
			$display("tb_indexed_sequence_store OK");
		end else begin
			$display("tb_indexed_sequence_store NOT OK");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/isq_pkg.sv
rtl/core/isq_cell.sv
rtl/core/isq_sel_tree.sv
rtl/core/indexed_sequence_store.sv
rtl/core/isq_checker.sv
tb/tb_indexed_sequence_store.sv
